/* hw/rtl/mqsb_pkg.sv */
`timescale 1ns / 1ps

package mqsb_pkg;

    // Store geometry
    localparam int SLOTS   = 16;
    localparam int QID_W   = 2;
    localparam int QUEUES  = 2 ** QID_W;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LINK_W  = $clog2(SLOTS + 1);
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;

    // Null link: one past the last slot
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_UPDATE = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic issue;   // latch item, start link/data read
        logic commit;  // update pointers and store, load result register
    } t_dp_cmd;

endpackage

/* hw/rtl/mqsb_ctrl.sv */
`timescale 1ns / 1ps

module mqsb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output mqsb_pkg::t_dp_cmd  o_cmd
);

    mqsb_pkg::t_state r_state;
    mqsb_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    // Result register can take a new result this cycle
    assign out_free = !r_out_valid || i_m_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mqsb_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = mqsb_pkg::S_UPDATE;
                end
            end
            mqsb_pkg::S_UPDATE: begin
                if (out_free) begin
                    n_state = mqsb_pkg::S_IDLE;
                end
            end
            default: n_state = mqsb_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            mqsb_pkg::S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.issue = i_s_tvalid;
            end
            mqsb_pkg::S_UPDATE: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mqsb_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

/* hw/rtl/mqsb_dp.sv */
`timescale 1ns / 1ps

module mqsb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mqsb_pkg::t_dp_cmd                   i_cmd,
    input  mqsb_pkg::t_op                       i_op,
    input  logic [mqsb_pkg::QID_W-1:0]          i_qid,
    input  logic signed [mqsb_pkg::DATA_W-1:0]  i_din,
    output mqsb_pkg::t_status                   o_status,
    output logic signed [mqsb_pkg::DATA_W-1:0]  o_dout
);

    // Pointer registers
    logic [mqsb_pkg::LINK_W-1:0] r_free_head;
    logic [mqsb_pkg::LINK_W-1:0] r_q_head [mqsb_pkg::QUEUES];
    logic [mqsb_pkg::LINK_W-1:0] r_q_tail [mqsb_pkg::QUEUES];

    // Link and data stores; link entries not yet written read as index + 1
    logic [mqsb_pkg::LINK_W-1:0]        r_link_mem [mqsb_pkg::SLOTS];
    logic [mqsb_pkg::SLOTS-1:0]         r_link_vld;
    logic signed [mqsb_pkg::DATA_W-1:0] r_data_mem [mqsb_pkg::SLOTS];

    // Registered reads
    logic [mqsb_pkg::LINK_W-1:0]        r_link_rd;
    logic                               r_link_rd_vld;
    logic [mqsb_pkg::SLOT_W-1:0]        r_rd_idx;
    logic signed [mqsb_pkg::DATA_W-1:0] r_data_rd;

    // Latched item
    mqsb_pkg::t_op                      r_op;
    logic [mqsb_pkg::QID_W-1:0]         r_qid;
    logic signed [mqsb_pkg::DATA_W-1:0] r_din;

    // Result register
    mqsb_pkg::t_status                  r_status;
    logic signed [mqsb_pkg::DATA_W-1:0] r_dout;

    logic [mqsb_pkg::LINK_W-1:0] rd_ptr;
    logic [mqsb_pkg::SLOT_W-1:0] rd_idx;
    logic [mqsb_pkg::LINK_W-1:0] link_q;
    logic [mqsb_pkg::LINK_W-1:0] cur_head;
    logic [mqsb_pkg::LINK_W-1:0] cur_tail;
    logic                        push_ok;
    logic                        pop_ok;
    logic                        lwr_en;
    logic [mqsb_pkg::SLOT_W-1:0] lwr_idx;

    // Read address: free head for push, queue head for pop
    assign rd_ptr = (i_op == mqsb_pkg::OP_POP) ? r_q_head[i_qid] : r_free_head;
    assign rd_idx = rd_ptr[mqsb_pkg::SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_link_rd     <= r_link_mem[rd_idx];
            r_link_rd_vld <= r_link_vld[rd_idx];
            r_rd_idx      <= rd_idx;
            r_data_rd     <= r_data_mem[rd_idx];
            r_op          <= i_op;
            r_qid         <= i_qid;
            r_din         <= i_din;
        end
    end

    // Link of the slot that was read
    assign link_q = r_link_rd_vld ? r_link_rd
                  : mqsb_pkg::LINK_W'(r_rd_idx) + mqsb_pkg::LINK_W'(1);

    assign cur_head = r_q_head[r_qid];
    assign cur_tail = r_q_tail[r_qid];
    assign push_ok  = (r_op == mqsb_pkg::OP_PUSH) && (r_free_head != mqsb_pkg::NIL);
    assign pop_ok   = (r_op == mqsb_pkg::OP_POP) && (cur_head != mqsb_pkg::NIL);

    // At most one link write per item: tail link on append, popped slot onto free list
    always_comb begin
        lwr_en  = 1'b0;
        lwr_idx = cur_tail[mqsb_pkg::SLOT_W-1:0];
        if (push_ok && (cur_head != mqsb_pkg::NIL)) begin
            lwr_en  = 1'b1;
            lwr_idx = cur_tail[mqsb_pkg::SLOT_W-1:0];
        end else if (pop_ok) begin
            lwr_en  = 1'b1;
            lwr_idx = cur_head[mqsb_pkg::SLOT_W-1:0];
        end
    end

    // Store writes; both cases write the old free head as the link value
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && lwr_en) begin
            r_link_mem[lwr_idx] <= r_free_head;
        end
        if (i_cmd.commit && push_ok) begin
            r_data_mem[r_free_head[mqsb_pkg::SLOT_W-1:0]] <= r_din;
        end
    end

    // Pointer update and link valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_link_vld  <= '0;
            for (int i = 0; i < mqsb_pkg::QUEUES; i++) begin
                r_q_head[i] <= mqsb_pkg::NIL;
                r_q_tail[i] <= mqsb_pkg::NIL;
            end
        end else if (i_cmd.commit) begin
            if (lwr_en) begin
                r_link_vld[lwr_idx] <= 1'b1;
            end
            if (push_ok) begin
                r_free_head <= link_q;
                r_q_tail[r_qid] <= r_free_head;
                if (cur_head == mqsb_pkg::NIL) begin
                    r_q_head[r_qid] <= r_free_head;
                end
            end else if (pop_ok) begin
                r_free_head <= cur_head;
                if (cur_head == cur_tail) begin
                    r_q_head[r_qid] <= mqsb_pkg::NIL;
                    r_q_tail[r_qid] <= mqsb_pkg::NIL;
                end else begin
                    r_q_head[r_qid] <= link_q;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_op == mqsb_pkg::OP_PUSH) begin
                r_status <= push_ok ? mqsb_pkg::ST_DONE : mqsb_pkg::ST_OVERFLOW;
            end else begin
                r_status <= pop_ok ? mqsb_pkg::ST_DONE : mqsb_pkg::ST_UNDERFLOW;
            end
            r_dout <= pop_ok ? r_data_rd : '0;
        end
    end

    assign o_status = r_status;
    assign o_dout   = r_dout;

endmodule

/* hw/rtl/multi_queue_shared_buffer_core.sv */
`timescale 1ns / 1ps
// Channel  | Direction | tdata          | tuser
// ---------+-----------+----------------+----------------------------
// s (cmd)  | in        | data_in [31:0] | cmd [0], queue_id [2:1]
// m (rsp)  | out       | data_out[31:0] | status [1:0]
//
// For each item, the transfer cycle reads the link and data stores at the
// free head (push) or queue head (pop); the update cycle updates pointers,
// writes at most one link and one data entry, and loads the result register.
// A result waiting on m does not block the next transfer on s; a stalled m
// holds the following item in its update cycle.
// Reset (i_rst_n low, synchronous) empties all queues and rebuilds the free
// list at once through per-slot link valid bits; no clearing pass.

module multi_queue_shared_buffer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic signed [mqsb_pkg::DATA_W-1:0]  i_s_tdata,  // data_in
    input  logic [2:0]                          i_s_tuser,  // cmd, queue_id
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic signed [mqsb_pkg::DATA_W-1:0]  o_m_tdata,  // data_out
    output logic [mqsb_pkg::STAT_W-1:0]         o_m_tuser   // status
);

    mqsb_pkg::t_dp_cmd cmd;
    mqsb_pkg::t_status status;

    mqsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    mqsb_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_op     (mqsb_pkg::t_op'(i_s_tuser[0])),
        .i_qid    (i_s_tuser[2:1]),
        .i_din    (i_s_tdata),
        .o_status (status),
        .o_dout   (o_m_tdata)
    );

    assign o_m_tuser = status;

endmodule

/* hw/rtl/mqsb_chk.sv */
`timescale 1ns / 1ps

module mqsb_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic signed [mqsb_pkg::DATA_W-1:0]  o_m_tdata,
    input logic [mqsb_pkg::STAT_W-1:0]         o_m_tuser
);

    // Result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped before transfer");

    // One item in flight: no back-to-back input transfers
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken during update");

    // Status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == mqsb_pkg::ST_DONE ||
                        o_m_tuser == mqsb_pkg::ST_OVERFLOW ||
                        o_m_tuser == mqsb_pkg::ST_UNDERFLOW))
        else $error("undefined status code");

    // Failed operations return zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != mqsb_pkg::ST_DONE |-> o_m_tdata == '0)
        else $error("nonzero data on failed operation");

    // Reset clears the result channel
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind multi_queue_shared_buffer_core mqsb_chk u_mqsb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
